[sv/ngg_pkg.sv]
// Package for the noise gate gain ramp: widths, register codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package ngg_pkg;

    // Gain fixed-point format: unsigned, GAIN_FRAC_BITS fraction bits, unity = 1 << frac
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int SAMPLE_W       = 16;
    localparam int GAIN_OUT_W     = 17;
    localparam int THRESH_W       = 16;
    localparam int FLOOR_W        = 16;
    localparam int STEP_W         = 17;
    localparam int HOLD_W         = 16;
    localparam int COUNT_W        = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;

    // Working width for the ramp add and subtract, with headroom
    localparam int CALC_W = ((GAIN_W > STEP_W) ? GAIN_W : STEP_W) + 2;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Register reset values
    localparam logic                RST_GATE_ENABLE = 1'b1;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD   = THRESH_W'(3277);
    localparam logic [FLOOR_W-1:0]  RST_FLOOR_GAIN  = FLOOR_W'(58982);
    localparam logic [STEP_W-1:0]   RST_RELEASE     = STEP_W'(3);
    localparam logic [STEP_W-1:0]   RST_ATTACK      = STEP_W'(14);
    localparam logic [HOLD_W-1:0]   RST_HOLD_LIMIT  = HOLD_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_ENABLE  = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_FLOOR_GAIN   = 3'd2,
        CFG_RELEASE_STEP = 3'd3,
        CFG_ATTACK_STEP  = 3'd4,
        CFG_HOLD_LIMIT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                gate_enable;
        logic [THRESH_W-1:0] threshold_level;
        logic [FLOOR_W-1:0]  floor_gain;
        logic [STEP_W-1:0]   release_step;
        logic [STEP_W-1:0]   attack_step;
        logic [HOLD_W-1:0]   hold_limit;
    } t_cfg;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_level;
        logic               gate_closed;
        logic [COUNT_W-1:0] loud_count;
    } t_gate_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       gate_closed_flag;
        logic [GAIN_OUT_W-1:0]      gain_now;
    } t_result;

endpackage
`default_nettype wire

[sv/ngg_in_if.sv]
// Input channel interface: one audio sample per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface ngg_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ngg_pkg::SAMPLE_W-1:0]      sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

[sv/ngg_out_if.sv]
// Output channel interface: scaled sample, gate flag and applied gain.
`timescale 1ns / 1ps
`default_nettype none
interface ngg_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ngg_pkg::SAMPLE_W-1:0]      sample_out;
    logic                                     gate_closed_flag;
    logic [ngg_pkg::GAIN_OUT_W-1:0]           gain_now;

    modport source (output valid, output sample_out, output gate_closed_flag,
                    output gain_now, input ready);
    modport sink   (input valid, input sample_out, input gate_closed_flag,
                    input gain_now, output ready);
endinterface
`default_nettype wire

[sv/ngg_gain_core.sv]
// Gate and gain ramp update plus sample scaling for one sample.
`timescale 1ns / 1ps
`default_nettype none
module ngg_gain_core (
    input  wire ngg_pkg::t_cfg                          i_cfg,
    input  wire ngg_pkg::t_gate_state                   i_state,
    input  wire logic signed [ngg_pkg::SAMPLE_W-1:0]    i_sample,
    output ngg_pkg::t_gate_state                        o_state,
    output ngg_pkg::t_result                            o_result
);
    localparam int CALC_W = ngg_pkg::CALC_W;
    localparam int PROD_W = ngg_pkg::SAMPLE_W + ngg_pkg::GAIN_W + 1;
    localparam int SHR_W  = PROD_W - ngg_pkg::GAIN_FRAC_BITS;

    logic [ngg_pkg::SAMPLE_W:0]            w_mag;
    logic                                  w_quiet;
    logic [CALC_W-1:0]                     w_gain;
    logic [CALC_W-1:0]                     w_floor;
    logic [CALC_W-1:0]                     w_unity;
    logic [CALC_W-1:0]                     w_sum;
    logic [ngg_pkg::COUNT_W-1:0]           w_count_inc;
    logic [ngg_pkg::GAIN_W-1:0]            w_gain_next;
    logic signed [ngg_pkg::GAIN_W:0]       w_gain_s;
    logic signed [PROD_W-1:0]              w_prod;
    logic signed [SHR_W-1:0]               w_shr;
    logic signed [ngg_pkg::SAMPLE_W-1:0]   w_scaled;

    // Magnitude, one bit wider so full-scale negative is 32768
    assign w_mag   = i_sample[ngg_pkg::SAMPLE_W-1]
                   ? (ngg_pkg::SAMPLE_W+1)'(-$signed({i_sample[ngg_pkg::SAMPLE_W-1], i_sample}))
                   : {1'b0, i_sample};
    assign w_quiet = w_mag < (ngg_pkg::SAMPLE_W+1)'(i_cfg.threshold_level);

    assign w_gain  = CALC_W'(i_state.gain_level);
    assign w_floor = CALC_W'(i_cfg.floor_gain);
    assign w_unity = CALC_W'(ngg_pkg::UNITY_GAIN);
    assign w_sum   = w_gain + CALC_W'(i_cfg.attack_step);

    assign w_count_inc = (i_state.loud_count != ngg_pkg::COUNT_MAX)
                       ? i_state.loud_count + 1'b1 : i_state.loud_count;

    always_comb begin
        o_state = i_state;
        if (i_cfg.gate_enable) begin
            if (w_quiet) begin
                if (!i_state.gate_closed) begin
                    o_state.gate_closed = 1'b1;
                    o_state.loud_count  = '0;
                end
                // ramp down, clamp at floor
                if (w_gain > w_floor) begin
                    if (CALC_W'(i_cfg.release_step) >= (w_gain - w_floor)) begin
                        o_state.gain_level = ngg_pkg::GAIN_W'(w_floor);
                    end else begin
                        o_state.gain_level =
                            ngg_pkg::GAIN_W'(w_gain - CALC_W'(i_cfg.release_step));
                    end
                end
            end else begin
                if (i_state.gate_closed) begin
                    o_state.loud_count = w_count_inc;
                    if (w_count_inc > ngg_pkg::COUNT_W'(i_cfg.hold_limit)) begin
                        o_state.gate_closed = 1'b0;
                    end
                end
                // ramp up, clamp at unity
                if (w_gain < w_unity) begin
                    o_state.gain_level = (w_sum > w_unity) ? ngg_pkg::UNITY_GAIN
                                                           : ngg_pkg::GAIN_W'(w_sum);
                end
            end
        end
    end

    assign w_gain_next = o_state.gain_level;
    assign w_gain_s    = $signed({1'b0, w_gain_next});
    assign w_prod      = PROD_W'(i_sample) * PROD_W'(w_gain_s);
    assign w_shr       = w_prod[PROD_W-1:ngg_pkg::GAIN_FRAC_BITS];

    // Floor shift, saturate to sample range
    always_comb begin
        if (w_shr > SHR_W'(32767)) begin
            w_scaled = 16'sh7FFF;
        end else if (w_shr < -SHR_W'(32768)) begin
            w_scaled = -16'sh8000;
        end else begin
            w_scaled = w_shr[ngg_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        if (i_cfg.gate_enable) begin
            o_result.sample_out = w_scaled;
            o_result.gain_now   = ngg_pkg::GAIN_OUT_W'(w_gain_next);
        end else begin
            o_result.sample_out = i_sample;
            o_result.gain_now   = ngg_pkg::GAIN_OUT_W'(ngg_pkg::UNITY_GAIN);
        end
        o_result.gate_closed_flag = o_state.gate_closed;
    end

endmodule
`default_nettype wire

[sv/noise_gate_gain_ramp.sv]
// Top level of the noise gate with attack/release gain ramp and hold counter.
//
//  Port group   Dir  Payload                                   Handshake
//  i_sample     in   sample_in (s16)                           valid/ready
//  o_result     out  sample_out (s16), gate_closed_flag, gain  valid/ready
//  i_cfg_*      in   index (3b), data (17b)                    write enable only
//
// One sample per cycle sustained while the output does not stall.
// Stage 1 holds the accepted sample, stage 2 is the result register. The
// gate/gain state updates when a sample moves from stage 1 into stage 2,
// so the compare, ramp clamp and multiply sit in that single path.
// Synchronous active-low reset sets valids, state, config to defaults, not payloads.
// Output stall backs up through stage 1; with both stages full, input ready drops.
`timescale 1ns / 1ps
`default_nettype none
module noise_gate_gain_ramp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    ngg_in_if.sink                                    i_sample,
    ngg_out_if.source                                 o_result,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ngg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ngg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    // configuration registers
    ngg_pkg::t_cfg                          r_cfg;
    // running gate state
    ngg_pkg::t_gate_state                   r_state;
    ngg_pkg::t_gate_state                   n_state;

    // stage 1: accepted sample
    logic                                   r_s1_valid;
    logic signed [ngg_pkg::SAMPLE_W-1:0]    r_s1_sample;

    // stage 2: result register
    logic                                   r_out_valid;
    ngg_pkg::t_result                       r_out;
    ngg_pkg::t_result                       n_out;

    logic                                   w_out_free;
    logic                                   w_s1_move;
    logic                                   w_in_ready;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign w_in_ready = !r_s1_valid || w_out_free;

    assign i_sample.ready = w_in_ready;

    assign o_result.valid            = r_out_valid;
    assign o_result.sample_out       = r_out.sample_out;
    assign o_result.gate_closed_flag = r_out.gate_closed_flag;
    assign o_result.gain_now         = r_out.gain_now;

    ngg_gain_core u_core (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (r_s1_sample),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // register write decode; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable     <= ngg_pkg::RST_GATE_ENABLE;
            r_cfg.threshold_level <= ngg_pkg::RST_THRESHOLD;
            r_cfg.floor_gain      <= ngg_pkg::RST_FLOOR_GAIN;
            r_cfg.release_step    <= ngg_pkg::RST_RELEASE;
            r_cfg.attack_step     <= ngg_pkg::RST_ATTACK;
            r_cfg.hold_limit      <= ngg_pkg::RST_HOLD_LIMIT;
        end else if (i_cfg_we) begin
            unique case (ngg_pkg::t_cfg_idx'(i_cfg_index))
                ngg_pkg::CFG_GATE_ENABLE: begin
                    r_cfg.gate_enable <= i_cfg_data[0];
                end
                ngg_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold_level <= i_cfg_data[ngg_pkg::THRESH_W-1:0];
                end
                ngg_pkg::CFG_FLOOR_GAIN: begin
                    r_cfg.floor_gain <= i_cfg_data[ngg_pkg::FLOOR_W-1:0];
                end
                ngg_pkg::CFG_RELEASE_STEP: begin
                    r_cfg.release_step <= i_cfg_data[ngg_pkg::STEP_W-1:0];
                end
                ngg_pkg::CFG_ATTACK_STEP: begin
                    r_cfg.attack_step <= i_cfg_data[ngg_pkg::STEP_W-1:0];
                end
                ngg_pkg::CFG_HOLD_LIMIT: begin
                    r_cfg.hold_limit <= i_cfg_data[ngg_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage 1 and stage 2 valids and gate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.gain_level  <= ngg_pkg::UNITY_GAIN;
            r_state.gate_closed <= 1'b0;
            r_state.loud_count  <= '0;
        end else begin
            if (w_in_ready) begin
                r_s1_valid <= i_sample.valid;
            end
            if (w_s1_move) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_sample.valid) begin
            r_s1_sample <= i_sample.sample_in;
        end
        if (w_s1_move) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
